FILE: src/sha1md_pkg.sv
package sha1md_pkg;

    // One input item: a message byte with its qualifiers
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } t_in_item;

    // One result item: a digest word with its position
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    // Five 32-bit words, element 0 is a / h0
    typedef logic [4:0][31:0] t_words;

    // Round function groups
    localparam logic [1:0] GRP_CH   = 2'd0;
    localparam logic [1:0] GRP_PAR1 = 2'd1;
    localparam logic [1:0] GRP_MAJ  = 2'd2;
    localparam logic [1:0] GRP_PAR2 = 2'd3;

    // Control from the sequencer to the round unit
    typedef struct packed {
        logic        shift_byte;
        logic [7:0]  byte_val;
        logic        shift_len;
        logic [63:0] len_bits;
        logic        init;
        logic        step;
        logic [1:0]  group;
    } t_core_ctl;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hEFCDAB89;
    localparam logic [31:0] IV2 = 32'h98BADCFE;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hC3D2E1F0;
    localparam t_words IV_WORDS = {IV4, IV3, IV2, IV1, IV0};

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    localparam logic [5:0] LEN_POS    = 6'd56;
    localparam logic [5:0] POS_LAST   = 6'd63;
    localparam logic [6:0] ROUND_LAST = 7'd79;
    localparam logic [2:0] WORD_LAST  = 3'd4;
    localparam logic [7:0] PAD_BYTE   = 8'h80;

    function automatic logic [31:0] round_k(input logic [1:0] grp);
        logic [31:0] k;
        case (grp)
            GRP_CH:   k = K0;
            GRP_PAR1: k = K1;
            GRP_MAJ:  k = K2;
            GRP_PAR2: k = K3;
            default:  k = K0;
        endcase
        return k;
    endfunction

endpackage

FILE: src/sha1md_core.sv
module sha1md_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sha1md_pkg::t_core_ctl i_ctl,
    input  sha1md_pkg::t_words    i_chain,
    output sha1md_pkg::t_words    o_work
);

    // Block window: word 0 sits in the top 32 bits
    logic [511:0] r_win, n_win;
    sha1md_pkg::t_words r_work, n_work;

    logic [31:0] w0, w2, w8, w13, w_x, w_next;
    logic [31:0] a, b, c, d, e, f, tmp;

    assign w0  = r_win[511:480];
    assign w2  = r_win[447:416];
    assign w8  = r_win[255:224];
    assign w13 = r_win[95:64];
    assign w_x = w13 ^ w8 ^ w2 ^ w0;
    assign w_next = {w_x[30:0], w_x[31]};

    assign a = r_work[0];
    assign b = r_work[1];
    assign c = r_work[2];
    assign d = r_work[3];
    assign e = r_work[4];

    // Select the round function
    always_comb begin
        case (i_ctl.group)
            sha1md_pkg::GRP_CH:  f = (b & c) | (~b & d);
            sha1md_pkg::GRP_MAJ: f = (b & c) | (b & d) | (c & d);
            default:             f = b ^ c ^ d;
        endcase
    end

    assign tmp = {a[26:0], a[31:27]} + f + e + w0 + sha1md_pkg::round_k(i_ctl.group);

    // Shift bytes, the length or the next schedule word into the window
    always_comb begin
        n_win = r_win;
        if (i_ctl.shift_byte) begin
            n_win = {r_win[503:0], i_ctl.byte_val};
        end else if (i_ctl.shift_len) begin
            n_win = {r_win[447:0], i_ctl.len_bits};
        end else if (i_ctl.step) begin
            n_win = {r_win[479:0], w_next};
        end
    end

    // Load or advance the working words
    always_comb begin
        n_work = r_work;
        if (i_ctl.init) begin
            n_work = i_chain;
        end else if (i_ctl.step) begin
            n_work[0] = tmp;
            n_work[1] = a;
            n_work[2] = {b[1:0], b[31:2]};
            n_work[3] = c;
            n_work[4] = d;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_work <= '0;
        end else begin
            r_work <= n_work;
        end
    end

    assign o_work = r_work;

endmodule

FILE: src/sha1_message_digest_top.sv
// SHA-1 message digest.
// Input channel: one transfer carries a byte, a flag that says the byte is
// present, and an end-of-message flag. An item with no byte and the end
// flag closes a message that ended on the previous byte; on its own it
// hashes the empty message. Bytes are taken one per cycle while
// o_in_stall is low.
// Each completed 64-byte block stalls the input for one pass of the shared
// round unit (one round per cycle) and an add into the chaining words; input
// is taken again in the cycle after the add.
// At the end of a message the block pads one byte per cycle up to byte 56,
// loads the 64-bit length, runs the final compression (one or
// two blocks), then presents the digest as five transfers, word 0 first.
// A receiver stall holds the current word; no new input is taken until the
// fifth word has been transferred, after which the chaining value, length
// and byte position return to their initial values.
// Reset (synchronous, active low) clears the sequencer, the length and the
// byte position, and loads the standard initial chaining value.
module sha1_message_digest_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  sha1md_pkg::t_in_item  i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output sha1md_pkg::t_out_item o_out_data
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_PAD_ONE  = 3'd1;
    localparam logic [2:0] S_PAD_ZERO = 3'd2;
    localparam logic [2:0] S_ROUND    = 3'd3;
    localparam logic [2:0] S_ADD      = 3'd4;
    localparam logic [2:0] S_OUT      = 3'd5;

    localparam logic [1:0] PH_NONE = 2'd0;
    localparam logic [1:0] PH_ONE  = 2'd1;
    localparam logic [1:0] PH_ZERO = 2'd2;
    localparam logic [1:0] PH_LEN  = 2'd3;

    logic [2:0]  r_state, n_state;
    logic [1:0]  r_phase, n_phase;
    logic [5:0]  r_pos, n_pos;
    logic [6:0]  r_round, n_round;
    logic [63:0] r_bitlen, n_bitlen;
    logic [2:0]  r_idx, n_idx;
    sha1md_pkg::t_words r_chain, n_chain;
    sha1md_pkg::t_words work;
    sha1md_pkg::t_core_ctl ctl;

    logic in_xfer, out_xfer;
    logic [1:0] group;

    assign in_xfer  = i_in_valid && (r_state == S_IDLE);
    assign out_xfer = (r_state == S_OUT) && !i_out_stall;

    // Pick the round group from the round count
    always_comb begin
        if (r_round < 7'd20) begin
            group = sha1md_pkg::GRP_CH;
        end else if (r_round < 7'd40) begin
            group = sha1md_pkg::GRP_PAR1;
        end else if (r_round < 7'd60) begin
            group = sha1md_pkg::GRP_MAJ;
        end else begin
            group = sha1md_pkg::GRP_PAR2;
        end
    end

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_round  = r_round;
        n_bitlen = r_bitlen;
        n_idx    = r_idx;
        n_chain  = r_chain;
        ctl      = '0;
        ctl.group    = group;
        ctl.len_bits = r_bitlen;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_phase = i_in_data.end_of_message ? PH_ONE : PH_NONE;
                    n_state = i_in_data.end_of_message ? S_PAD_ONE : S_IDLE;
                    if (i_in_data.byte_valid) begin
                        ctl.shift_byte = 1'b1;
                        ctl.byte_val   = i_in_data.data_byte;
                        n_bitlen       = r_bitlen + 64'd8;
                        n_pos          = r_pos + 6'd1;
                        if (r_pos == sha1md_pkg::POS_LAST) begin
                            ctl.init = 1'b1;
                            n_state  = S_ROUND;
                        end
                    end
                end
            end
            S_PAD_ONE: begin
                ctl.shift_byte = 1'b1;
                ctl.byte_val   = sha1md_pkg::PAD_BYTE;
                n_pos          = r_pos + 6'd1;
                n_phase        = PH_ZERO;
                n_state        = S_PAD_ZERO;
                if (r_pos == sha1md_pkg::POS_LAST) begin
                    ctl.init = 1'b1;
                    n_state  = S_ROUND;
                end
            end
            S_PAD_ZERO: begin
                if (r_pos == sha1md_pkg::LEN_POS) begin
                    ctl.shift_len = 1'b1;
                    ctl.init      = 1'b1;
                    n_pos         = '0;
                    n_phase       = PH_LEN;
                    n_state       = S_ROUND;
                end else begin
                    ctl.shift_byte = 1'b1;
                    ctl.byte_val   = '0;
                    n_pos          = r_pos + 6'd1;
                    if (r_pos == sha1md_pkg::POS_LAST) begin
                        ctl.init = 1'b1;
                        n_state  = S_ROUND;
                    end
                end
            end
            S_ROUND: begin
                ctl.step = 1'b1;
                n_round  = r_round + 7'd1;
                if (r_round == sha1md_pkg::ROUND_LAST) begin
                    n_round = '0;
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                for (int i = 0; i < 5; i++) begin
                    n_chain[i] = r_chain[i] + work[i];
                end
                case (r_phase)
                    PH_NONE: n_state = S_IDLE;
                    PH_ONE:  n_state = S_PAD_ONE;
                    PH_ZERO: n_state = S_PAD_ZERO;
                    PH_LEN: begin
                        n_state = S_OUT;
                        n_idx   = '0;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_OUT: begin
                if (out_xfer) begin
                    n_idx   = r_idx + 3'd1;
                    n_chain = {r_chain[0], r_chain[4:1]};
                    if (r_idx == sha1md_pkg::WORD_LAST) begin
                        n_chain  = sha1md_pkg::IV_WORDS;
                        n_bitlen = '0;
                        n_pos    = '0;
                        n_phase  = PH_NONE;
                        n_idx    = '0;
                        n_state  = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= PH_NONE;
            r_pos    <= '0;
            r_round  <= '0;
            r_bitlen <= '0;
            r_idx    <= '0;
            r_chain  <= sha1md_pkg::IV_WORDS;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_round  <= n_round;
            r_bitlen <= n_bitlen;
            r_idx    <= n_idx;
            r_chain  <= n_chain;
        end
    end

    sha1md_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_chain (r_chain),
        .o_work  (work)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_out_data.digest_word = r_chain[0];
    assign o_out_data.word_index  = r_idx;
    assign o_out_data.last_word   = (r_idx == sha1md_pkg::WORD_LAST);

endmodule

FILE: src/sha1md_checker.sv
module sha1md_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input sha1md_pkg::t_in_item  i_in_data,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input sha1md_pkg::t_out_item o_out_data
);

    logic out_xfer;
    assign out_xfer = o_out_valid && !i_out_stall;

    // No digest word right after reset
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // Input is held off while the digest is emitted
    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input open during digest output");

    // Digest words follow back to back in index order
    a_next_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && !o_out_data.last_word |=>
            o_out_valid && (o_out_data.word_index == $past(o_out_data.word_index) + 3'd1))
        else $error("digest word sequence broken");

    // Output ends after the last word
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && o_out_data.last_word |=> !o_out_valid)
        else $error("output continues after last word");

    // A stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output changed");

endmodule

bind sha1_message_digest_top sha1md_checker u_sha1md_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
